/* hw/rtl/mlpf_pkg.sv */
// mlpf_pkg: sizes, transaction types, state codes and arithmetic helpers
// for the mlp forward pass / squared-error block
// no dependencies; used by every file under hw/rtl
package mlpf_pkg;

   // network shape
   localparam int INPUT_COUNT   = 8;
   localparam int LAYER_WIDTH   = 8;
   localparam int HIDDEN_LAYERS = 2;

   // derived sizes
   localparam int MAX_FANIN   = (INPUT_COUNT > LAYER_WIDTH) ? INPUT_COUNT : LAYER_WIDTH;
   localparam int CNT_W       = $clog2(MAX_FANIN + 1);
   localparam int BUF_IDX_W   = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
   localparam int BUF_DEPTH   = 2 * (2 ** BUF_IDX_W);
   localparam int ACT_DEPTH   = (HIDDEN_LAYERS * LAYER_WIDTH > 1) ?
                                HIDDEN_LAYERS * LAYER_WIDTH : 2;
   localparam int ACT_ADDR_W  = $clog2(ACT_DEPTH);
   localparam int LAYER_W     = (HIDDEN_LAYERS > 0) ? $clog2(HIDDEN_LAYERS + 1) : 1;
   localparam int PROD_W      = 48;
   localparam int ACC_W       = PROD_W + CNT_W;

   localparam logic [CNT_W-1:0]      IN_COUNT_C = CNT_W'(INPUT_COUNT);
   localparam logic [CNT_W-1:0]      IN_LAST    = CNT_W'(INPUT_COUNT - 1);
   localparam logic [CNT_W-1:0]      HID_LAST   = CNT_W'(LAYER_WIDTH - 1);
   localparam logic [LAYER_W-1:0]    OUT_LAYER  = LAYER_W'(HIDDEN_LAYERS);
   localparam logic [ACT_ADDR_W-1:0] ACT_STRIDE = ACT_ADDR_W'(LAYER_WIDTH);

   // weight pattern position (index mod 5) steps
   localparam logic [2:0] COL_STEP     = 3'(LAYER_WIDTH % 5);
   localparam logic [2:0] IN_OFF_STEP  = 3'((INPUT_COUNT * LAYER_WIDTH) % 5);
   localparam logic [2:0] HID_OFF_STEP = 3'((LAYER_WIDTH * LAYER_WIDTH) % 5);

   localparam logic [32:0] SQ_LIMIT = 33'd3037000499;
   localparam logic [62:0] SQ_MAX   = {63{1'b1}};

   typedef struct packed {
      logic signed [15:0] x_element;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic signed [31:0] target_value;
      logic signed [31:0] predicted_value;
      logic [62:0]        squared_error;
      logic               length_error;
   } rsp_type;

   // one closed vector handed from front to back
   typedef struct packed {
      logic signed [31:0] target;
      logic [CNT_W-1:0]   count;
      logic               length_error;
      logic               bank;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_msg_type;

   typedef struct packed {
      logic                 en;
      logic [BUF_IDX_W:0]   addr;
      logic signed [15:0]   data;
   } buf_wr_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RUN,
      BK_DRAIN,
      BK_DIFF,
      BK_SQUARE,
      BK_DONE
   } back_state_type;

   function automatic logic [2:0] add_mod5(input logic [2:0] a, input logic [2:0] b);
      logic [3:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd5) begin
         s = s - 4'd5;
      end
      return s[2:0];
   endfunction

   // pattern -0.2,-0.1,0,0.1,0.2 in q1.15
   function automatic logic signed [15:0] weight_of(input logic [2:0] r);
      logic signed [15:0] w;
      case (r)
         3'd0:    w = -16'sd6554;
         3'd1:    w = -16'sd3277;
         3'd2:    w = 16'sd0;
         3'd3:    w = 16'sd3277;
         3'd4:    w = 16'sd6554;
         default: w = 16'sd0;
      endcase
      return w;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // round half up to q16.16 (floor shift by 15) and saturate
   function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0] v;
      logic signed [ACC_W:0] q;
      logic signed [31:0]    r;
      v = {acc[ACC_W-1], acc} + (ACC_W+1)'(16384);
      q = v >>> 15;
      if ((&q[ACC_W:31]) || !(|q[ACC_W:31])) begin
         r = q[31:0];
      end else begin
         r = q[ACC_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/mlpf_front.sv */
// mlpf_front: accepts input elements, keeps the target sum and element count,
// writes the input buffer and hands closed vectors to the job queue
// depends on mlpf_pkg
module mlpf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mlpf_pkg::req_type    req_data,
   input  logic                 queue_full,
   output mlpf_pkg::job_msg_type push,
   output mlpf_pkg::buf_wr_type  buf_wr
);

   logic [mlpf_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [31:0]         target_ff, target_in;
   logic                       ovf_ff, ovf_in;
   logic                       bank_ff, bank_in;

   logic                       accept;
   logic                       take;
   logic signed [20:0]         scaled;
   logic signed [20:0]         term;
   logic signed [31:0]         target_new;
   logic [mlpf_pkg::CNT_W-1:0] cnt_new;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign take      = cnt_ff < mlpf_pkg::IN_COUNT_C;

   always_comb begin
      scaled     = {req_data.x_element[15], req_data.x_element, 4'b0000};
      term       = cnt_ff[0] ? -scaled : scaled;
      target_new = mlpf_pkg::sat32({target_ff[31], target_ff} + {{12{term[20]}}, term});
      cnt_new    = take ? cnt_ff + 1'b1 : cnt_ff;
   end

   always_comb begin
      cnt_in    = cnt_ff;
      target_in = target_ff;
      ovf_in    = ovf_ff;
      bank_in   = bank_ff;
      if (accept) begin
         if (req_data.last_element) begin
            cnt_in    = '0;
            target_in = '0;
            ovf_in    = 1'b0;
            bank_in   = !bank_ff;
         end else begin
            cnt_in    = cnt_new;
            target_in = take ? target_new : target_ff;
            ovf_in    = ovf_ff || !take;
         end
      end
   end

   always_comb begin
      push.valid            = accept && req_data.last_element;
      push.job.target       = take ? target_new : target_ff;
      push.job.count        = cnt_new;
      push.job.length_error = ovf_ff || !take || (cnt_new != mlpf_pkg::IN_COUNT_C);
      push.job.bank         = bank_ff;
      buf_wr.en             = accept && take;
      buf_wr.addr           = {bank_ff, cnt_ff[mlpf_pkg::BUF_IDX_W-1:0]};
      buf_wr.data           = req_data.x_element;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         target_ff <= '0;
         ovf_ff    <= 1'b0;
         bank_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         target_ff <= target_in;
         ovf_ff    <= ovf_in;
         bank_ff   <= bank_in;
      end
   end

endmodule

/* hw/rtl/mlpf_queue.sv */
// mlpf_queue: two-entry job queue between front and back
// depends on mlpf_pkg
module mlpf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  mlpf_pkg::job_msg_type push,
   input  logic                  pop,
   output logic                  full,
   output mlpf_pkg::job_msg_type head
);

   mlpf_pkg::job_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_pop;

   assign full   = count_ff == 2'd2;
   assign do_pop = pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push.valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, do_pop};
      head.valid = count_ff != 2'd0;
      head.job   = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/mlpf_back.sv */
// mlpf_back: forward pass on one pipelined mac unit, then error and square,
// holds the input buffer, activation memory and result register
// depends on mlpf_pkg
module mlpf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mlpf_pkg::job_msg_type head,
   output logic                  pop,
   input  mlpf_pkg::buf_wr_type  buf_wr,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mlpf_pkg::rsp_type     rsp_data
);

   localparam int AW  = mlpf_pkg::ACT_ADDR_W;
   localparam int CW  = mlpf_pkg::CNT_W;
   localparam int LW  = mlpf_pkg::LAYER_W;
   localparam int ACW = mlpf_pkg::ACC_W;
   localparam int PW  = mlpf_pkg::PROD_W;

   mlpf_pkg::back_state_type state_ff, state_in;

   // sequencer
   logic [LW-1:0] layer_ff, layer_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] k_ff, k_in;
   logic [2:0]    res_off_ff, res_off_in;
   logic [2:0]    res_k_ff, res_k_in;
   logic [2:0]    res_ff, res_in;
   logic [AW-1:0] rd_base_ff, rd_base_in;
   logic [AW-1:0] wr_base_ff, wr_base_in;

   // memories
   logic signed [15:0] in_buf [mlpf_pkg::BUF_DEPTH];
   logic signed [31:0] act_mem [mlpf_pkg::ACT_DEPTH];
   logic signed [15:0] buf_rd_ff;
   logic signed [31:0] act_rd_ff;

   // mac pipeline
   logic               s1_valid_ff, s1_first_ff, s1_last_ff, s1_src_in_ff, s1_zero_ff;
   logic               s1_out_ff;
   logic signed [15:0] s1_weight_ff;
   logic [AW-1:0]      s1_wa_ff;
   logic               s2_valid_ff, s2_first_ff, s2_last_ff, s2_out_ff;
   logic signed [PW-1:0] s2_prod_ff;
   logic [AW-1:0]      s2_wa_ff;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic               s3_valid_ff, s3_out_ff;
   logic [AW-1:0]      s3_wa_ff;

   // loss
   logic signed [31:0] pred_ff;
   logic [31:0]        mag_ff;
   logic               lim_ff;
   logic [62:0]        sq_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   mlpf_pkg::rsp_type  rsp_data_ff;

   // control
   logic          issue, start, advance, do_diff, do_square, load;
   logic          pipe_empty, out_free, is_out_layer;
   logic          j_end, k_end;
   logic [CW-1:0] n_in_last, n_out_last;
   logic [2:0]    col_step, off_step, res_k_next, off_next;

   logic signed [31:0]   operand;
   logic signed [PW-1:0] prod;
   logic signed [31:0]   rnd;
   logic signed [32:0]   diff;
   logic [32:0]          mag;
   logic [63:0]          sq_full;

   assign is_out_layer = layer_ff == mlpf_pkg::OUT_LAYER;
   assign n_in_last    = (layer_ff == '0) ? mlpf_pkg::IN_LAST : mlpf_pkg::HID_LAST;
   assign n_out_last   = is_out_layer ? '0 : mlpf_pkg::HID_LAST;
   assign col_step     = is_out_layer ? 3'd1 : mlpf_pkg::COL_STEP;
   assign off_step     = (layer_ff == '0) ? mlpf_pkg::IN_OFF_STEP : mlpf_pkg::HID_OFF_STEP;
   assign j_end        = j_ff == n_in_last;
   assign k_end        = k_ff == n_out_last;
   assign pipe_empty   = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mlpf_pkg::BK_IDLE: begin
            if (head.valid) state_in = mlpf_pkg::BK_RUN;
         end
         mlpf_pkg::BK_RUN: begin
            if (j_end && k_end) state_in = mlpf_pkg::BK_DRAIN;
         end
         mlpf_pkg::BK_DRAIN: begin
            if (pipe_empty) begin
               state_in = is_out_layer ? mlpf_pkg::BK_DIFF : mlpf_pkg::BK_RUN;
            end
         end
         mlpf_pkg::BK_DIFF:   state_in = mlpf_pkg::BK_SQUARE;
         mlpf_pkg::BK_SQUARE: state_in = mlpf_pkg::BK_DONE;
         mlpf_pkg::BK_DONE: begin
            if (out_free) state_in = mlpf_pkg::BK_IDLE;
         end
         default: state_in = mlpf_pkg::BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      issue     = 1'b0;
      start     = 1'b0;
      advance   = 1'b0;
      do_diff   = 1'b0;
      do_square = 1'b0;
      load      = 1'b0;
      case (state_ff)
         mlpf_pkg::BK_IDLE:   start     = head.valid;
         mlpf_pkg::BK_RUN:    issue     = 1'b1;
         mlpf_pkg::BK_DRAIN:  advance   = pipe_empty && !is_out_layer;
         mlpf_pkg::BK_DIFF:   do_diff   = 1'b1;
         mlpf_pkg::BK_SQUARE: do_square = 1'b1;
         mlpf_pkg::BK_DONE:   load      = out_free;
         default: ;
      endcase
   end

   assign pop = load;

   // sequencer counters, weight position kept mod 5
   always_comb begin
      layer_in   = layer_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      res_off_in = res_off_ff;
      res_k_in   = res_k_ff;
      res_in     = res_ff;
      rd_base_in = rd_base_ff;
      wr_base_in = wr_base_ff;
      res_k_next = mlpf_pkg::add_mod5(res_k_ff, 3'd1);
      off_next   = mlpf_pkg::add_mod5(res_off_ff, off_step);
      if (start) begin
         layer_in   = '0;
         j_in       = '0;
         k_in       = '0;
         res_off_in = 3'd0;
         res_k_in   = 3'd0;
         res_in     = 3'd0;
         rd_base_in = '0;
         wr_base_in = '0;
      end
      if (issue) begin
         if (j_end) begin
            j_in = '0;
            if (!k_end) begin
               k_in     = k_ff + 1'b1;
               res_k_in = res_k_next;
               res_in   = res_k_next;
            end
         end else begin
            j_in   = j_ff + 1'b1;
            res_in = mlpf_pkg::add_mod5(res_ff, col_step);
         end
      end
      if (advance) begin
         layer_in   = layer_ff + 1'b1;
         j_in       = '0;
         k_in       = '0;
         res_off_in = off_next;
         res_k_in   = off_next;
         res_in     = off_next;
         rd_base_in = wr_base_ff;
         wr_base_in = wr_base_ff + mlpf_pkg::ACT_STRIDE;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         in_buf[buf_wr.addr] <= buf_wr.data;
      end
      buf_rd_ff <= in_buf[{head.job.bank, j_ff[mlpf_pkg::BUF_IDX_W-1:0]}];
   end

   assign rnd = mlpf_pkg::round_sat(acc_ff);

   always_ff @(posedge clock) begin
      if (s3_valid_ff && !s3_out_ff) begin
         act_mem[s3_wa_ff] <= rnd;
      end
      act_rd_ff <= act_mem[rd_base_ff + AW'(j_ff)];
   end

   // mac datapath
   always_comb begin
      if (s1_zero_ff) begin
         operand = '0;
      end else if (s1_src_in_ff) begin
         operand = {{12{buf_rd_ff[15]}}, buf_rd_ff, 4'b0000};
      end else begin
         operand = act_rd_ff;
      end
      prod   = operand * s1_weight_ff;
      acc_in = s2_first_ff ? {{(ACW-PW){s2_prod_ff[PW-1]}}, s2_prod_ff}
                           : acc_ff + {{(ACW-PW){s2_prod_ff[PW-1]}}, s2_prod_ff};
      diff    = {head.job.target[31], head.job.target} - {pred_ff[31], pred_ff};
      mag     = diff[32] ? 33'(-diff) : 33'(diff);
      sq_full = {32'b0, mag_ff} * {32'b0, mag_ff};
   end

   always_ff @(posedge clock) begin
      s1_first_ff  <= j_ff == '0;
      s1_last_ff   <= j_end;
      s1_src_in_ff <= layer_ff == '0;
      s1_zero_ff   <= (layer_ff == '0) && (j_ff >= head.job.count);
      s1_weight_ff <= mlpf_pkg::weight_of(res_ff);
      s1_out_ff    <= is_out_layer;
      s1_wa_ff     <= wr_base_ff + AW'(k_ff);
      s2_first_ff  <= s1_first_ff;
      s2_last_ff   <= s1_last_ff;
      s2_out_ff    <= s1_out_ff;
      s2_wa_ff     <= s1_wa_ff;
      s2_prod_ff   <= prod;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      s3_out_ff <= s2_out_ff;
      s3_wa_ff  <= s2_wa_ff;
      if (s3_valid_ff && s3_out_ff) begin
         pred_ff <= rnd;
      end
      if (do_diff) begin
         mag_ff <= mag[31:0];
         lim_ff <= mag > mlpf_pkg::SQ_LIMIT;
      end
      if (do_square) begin
         sq_ff <= lim_ff ? mlpf_pkg::SQ_MAX : sq_full[62:0];
      end
      if (load) begin
         rsp_data_ff.target_value    <= head.job.target;
         rsp_data_ff.predicted_value <= pred_ff;
         rsp_data_ff.squared_error   <= sq_ff;
         rsp_data_ff.length_error    <= head.job.length_error;
      end
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlpf_pkg::BK_IDLE;
         layer_ff     <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         res_off_ff   <= 3'd0;
         res_k_ff     <= 3'd0;
         res_ff       <= 3'd0;
         rd_base_ff   <= '0;
         wr_base_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         layer_ff     <= layer_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         res_off_ff   <= res_off_in;
         res_k_ff     <= res_k_in;
         res_ff       <= res_in;
         rd_base_ff   <= rd_base_in;
         wr_base_ff   <= wr_base_in;
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && s2_last_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/mlp_forward_mse_loss.sv */
// mlp_forward_mse_loss: top level of the linear mlp forward pass with
// squared-error loss; front, job queue and mac back end
// depends on mlpf_pkg, mlpf_front, mlpf_queue, mlpf_back
//
//  channel | ports                        | direction | transaction
//  --------+------------------------------+-----------+----------------------------
//  req     | req_valid/req_ready/req_data | in        | one vector element + last
//  rsp     | rsp_valid/rsp_ready/rsp_data | out       | target, prediction, error
//
// the front takes one element per cycle while req_ready is high. a closed vector
//   runs through the single mac pipeline of the back end: the default shape has
//   136 macs.
// the queue holds two closed vectors; the input buffer has one bank for each,
//   so req_ready drops only while both banks wait on the back end.
// reset clears counters, target sum, queue and the result valid flag; memories
//   need no clearing (missing elements are masked by the element count).
// a stalled rsp holds its result; the back end then waits and the front keeps
//   filling the next vector.
module mlp_forward_mse_loss (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mlpf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mlpf_pkg::rsp_type rsp_data
);

   mlpf_pkg::job_msg_type q_push;
   mlpf_pkg::job_msg_type q_head;
   mlpf_pkg::buf_wr_type  buf_wr;
   logic                  q_full;
   logic                  q_pop;

   // element intake, target sum, vector close
   mlpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (q_full),
      .push       (q_push),
      .buf_wr     (buf_wr)
   );

   // closed vectors waiting for the mac pipeline
   mlpf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (q_pop),
      .full  (q_full),
      .head  (q_head)
   );

   // layer sequencer, mac pipeline, loss and result register
   mlpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .pop       (q_pop),
      .buf_wr    (buf_wr),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a vector is never closed into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push.valid |-> !q_full)
      else $error("vector closed while job queue full");

   // the back end only retires a job that exists
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_head.valid)
      else $error("job retired from empty queue");

   // equal target and prediction give zero loss
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.target_value == rsp_data.predicted_value))
         |-> (rsp_data.squared_error == '0))
      else $error("nonzero loss for matching prediction");

   // a result appears only after its job was retired
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_pop))
      else $error("result without retired job");

endmodule

/* test/tb_mlp_forward_mse_loss.sv */
`timescale 1ns / 1ps
// tb_mlp_forward_mse_loss: self-checking bench for the linear mlp forward pass with
// squared-error loss; streams vector elements in and scores every closed vector
// depends on mlpf_pkg (sizes, transaction types) and mlp_forward_mse_loss
module tb_mlp_forward_mse_loss;

   localparam int RANDOM_ITEMS   = 700;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int HOLD_CYCLES    = 400;   // long rsp back-pressure stretch
   localparam int MAX_REPORTS    = 40;

   localparam longint unsigned SQR_IN_LIMIT = 64'd3037000499;

   // typed-in results: all-zero vector, full length or with a length error
   localparam mlpf_pkg::rsp_type ZERO_FULL  = '{target_value: 0, predicted_value: 0,
                                                squared_error: 0, length_error: 1'b0};
   localparam mlpf_pkg::rsp_type ZERO_SHORT = '{target_value: 0, predicted_value: 0,
                                                squared_error: 0, length_error: 1'b1};

   typedef struct {
      mlpf_pkg::req_type item;
      bit                typed;         // use typed_result instead of the predictor
      mlpf_pkg::rsp_type typed_result;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   mlpf_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   mlpf_pkg::rsp_type rsp_data;

   // predictor state: one open vector
   logic signed [15:0] elem_buf [mlpf_pkg::INPUT_COUNT];
   logic signed [31:0] target_sum = '0;
   int                 elem_count = 0;
   bit                 extra_seen = 1'b0;

   mlpf_pkg::rsp_type pending_results [$];
   stim_row_type      directed_rows [$];
   mlpf_pkg::rsp_type oldest_result;

   int errors         = 0;
   int items_sent     = 0;
   int vectors_closed = 0;
   int results_seen   = 0;
   int length_flags   = 0;
   int quiet_cycles   = 0;

   mlp_forward_mse_loss dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function automatic logic signed [31:0] clip_q16(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // one rounding step from the wide sum down to q16.16: half up, floor shift
   function automatic logic signed [31:0] q15_sum_to_q16(input longint acc);
      longint v;
      v = acc + 64'sd16384;
      return clip_q16(v >>> 15);
   endfunction

   // weights never change: position in the flat store picks from the 5-entry pattern
   function automatic logic signed [15:0] pattern_weight(input int idx);
      case (idx % 5)
         0:       return -16'sd6554;
         1:       return -16'sd3277;
         3:       return 16'sd3277;
         4:       return 16'sd6554;
         default: return 16'sd0;
      endcase
   endfunction

   // folds one element into the open vector; on the closing element it runs the
   // network and hands back the scored result
   task automatic score_element(input mlpf_pkg::req_type item, output bit closes,
                                output mlpf_pkg::rsp_type res);
      longint             layer_in [mlpf_pkg::MAX_FANIN];
      longint             layer_out [mlpf_pkg::LAYER_WIDTH];
      longint             acc;
      longint             term;
      longint             diff;
      longint unsigned    mag;
      longint unsigned    sq;
      int                 n_in;
      int                 base;
      logic signed [31:0] pred;
      closes = 1'b0;
      res = '0;
      // elements past the vector length are dropped and only remembered
      if (elem_count < mlpf_pkg::INPUT_COUNT) begin
         term = longint'(item.x_element) * 16;
         if (elem_count % 2 == 1) begin
            term = -term;
         end
         elem_buf[elem_count] = item.x_element;
         target_sum = clip_q16(longint'(target_sum) + term);
         elem_count++;
      end else begin
         extra_seen = 1'b1;
      end
      if (!item.last_element) begin
         return;
      end

      // missing elements read as zero since the buffer is cleared per vector
      for (int j = 0; j < mlpf_pkg::INPUT_COUNT; j++) begin
         layer_in[j] = longint'(elem_buf[j]) * 16;
      end
      n_in = mlpf_pkg::INPUT_COUNT;
      base = 0;
      for (int l = 0; l < mlpf_pkg::HIDDEN_LAYERS; l++) begin
         for (int k = 0; k < mlpf_pkg::LAYER_WIDTH; k++) begin
            acc = 0;
            for (int j = 0; j < n_in; j++) begin
               acc += layer_in[j] * pattern_weight(base + j * mlpf_pkg::LAYER_WIDTH + k);
            end
            layer_out[k] = q15_sum_to_q16(acc);
         end
         base += n_in * mlpf_pkg::LAYER_WIDTH;
         for (int k = 0; k < mlpf_pkg::LAYER_WIDTH; k++) begin
            layer_in[k] = layer_out[k];
         end
         n_in = mlpf_pkg::LAYER_WIDTH;
      end
      // single linear output unit
      acc = 0;
      for (int j = 0; j < n_in; j++) begin
         acc += layer_in[j] * pattern_weight(base + j);
      end
      pred = q15_sum_to_q16(acc);

      diff = longint'(target_sum) - longint'(pred);
      mag = (diff < 0) ? longint'(-diff) : longint'(diff);
      sq = (mag > SQR_IN_LIMIT) ? {1'b0, {63{1'b1}}} : mag * mag;

      res.target_value    = target_sum;
      res.predicted_value = pred;
      res.squared_error   = sq[62:0];
      res.length_error    = extra_seen || (elem_count < mlpf_pkg::INPUT_COUNT);
      closes = 1'b1;

      for (int j = 0; j < mlpf_pkg::INPUT_COUNT; j++) begin
         elem_buf[j] = '0;
      end
      target_sum = '0;
      elem_count = 0;
      extra_seen = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // req side
   // ---------------------------------------------------------------

   task automatic add_row(input logic signed [15:0] x, input bit last_el, input bit typed,
                          input mlpf_pkg::rsp_type res);
      stim_row_type row;
      row.item.x_element    = x;
      row.item.last_element = last_el;
      row.typed             = typed;
      row.typed_result      = res;
      directed_rows.push_back(row);
   endtask

   // valid is only lowered when a gap follows, so a back-to-back transaction
   // never sees valid dropped and raised in the same step
   task automatic send_element(input mlpf_pkg::req_type item, input bit steady,
                               input bit typed, input mlpf_pkg::rsp_type typed_res);
      int                gap;
      bit                closes;
      mlpf_pkg::rsp_type res;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      score_element(item, closes, res);
      if (closes) begin
         pending_results.push_back(typed ? typed_res : res);
         vectors_closed++;
      end
   endtask

   initial begin
      mlpf_pkg::req_type item;
      int                random_items;
      int                vec_len;
      int                kind;
      bit                steady;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      random_items = 0;
      for (int j = 0; j < mlpf_pkg::INPUT_COUNT; j++) begin
         elem_buf[j] = '0;
      end

      // directed: missing elements right after reset
      add_row(16'sd0, 1'b1, 1'b1, ZERO_SHORT);
      // all-zero vector of exactly the right length
      for (int i = 0; i < mlpf_pkg::INPUT_COUNT; i++) begin
         add_row(16'sd0, i == mlpf_pkg::INPUT_COUNT - 1, 1'b1, ZERO_FULL);
      end
      // extremes: signs line up with the alternating sum, largest target
      for (int i = 0; i < mlpf_pkg::INPUT_COUNT; i++) begin
         add_row((i % 2 == 0) ? 16'sh7fff : 16'sh8000, i == mlpf_pkg::INPUT_COUNT - 1,
                 1'b0, '0);
      end
      // extra element: the large one after a full vector is ignored but flagged
      for (int i = 0; i <= mlpf_pkg::INPUT_COUNT; i++) begin
         add_row((i == mlpf_pkg::INPUT_COUNT) ? 16'sh7fff : 16'sd0,
                 i == mlpf_pkg::INPUT_COUNT, 1'b1, ZERO_SHORT);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_element(directed_rows[r].item, 1'b0, directed_rows[r].typed,
                      directed_rows[r].typed_result);
      end

      // random: mostly full-length vectors with random content, some short and
      // some over-long ones; now and then a vector without gaps
      while (random_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 19);
         if (kind < 15) begin
            vec_len = mlpf_pkg::INPUT_COUNT;
         end else if (kind < 18) begin
            vec_len = $urandom_range(1, mlpf_pkg::INPUT_COUNT - 1);
         end else begin
            vec_len = $urandom_range(mlpf_pkg::INPUT_COUNT + 1, mlpf_pkg::INPUT_COUNT + 4);
         end
         steady = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < vec_len; i++) begin
            case ($urandom_range(0, 9))
               0:       item.x_element = 16'sh7fff;
               1:       item.x_element = 16'sh8000;
               2:       item.x_element = 16'sd0;
               3:       item.x_element = -16'sd1;
               default: item.x_element = 16'($urandom);
            endcase
            item.last_element = (i == vec_len - 1);
            send_element(item, steady, 1'b0, '0);
         end
         random_items += vec_len;
      end
      req_valid <= 1'b0;

      // wait for the outstanding results, then give stray ones time to show
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d elements in %0d vectors (directed + random), %0d results checked",
               items_sent, vectors_closed, results_seen);
      $display("%0d results carried a length error, %0d mismatches", length_flags, errors);
      if (errors == 0) begin
         $display("tb_mlp_forward_mse_loss OK");
      end else begin
         $display("tb_mlp_forward_mse_loss NOT OK");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // rsp side
   // ---------------------------------------------------------------

   // random stalls per transaction, now and then a quiet run of eight results, and
   // two long holds so the queue and both buffer banks fill and req_ready drops
   initial begin
      int stall;
      int taken;
      bit calm;
      rsp_ready = 1'b0;
      taken = 0;
      calm = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 8 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         stall = calm ? 0 : $urandom_range(0, 3);
         if (taken == 3 || taken == 60) begin
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   task automatic note_mismatch(input string field, input longint want_v,
                                input longint got_v);
      if (errors < MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want_v, got_v);
      end
      errors++;
   endtask

   // compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected result, target_value", 0,
                          longint'(rsp_data.target_value));
         end else begin
            oldest_result = pending_results.pop_front();
            results_seen++;
            if (oldest_result.length_error) begin
               length_flags++;
            end
            if (rsp_data.target_value !== oldest_result.target_value) begin
               note_mismatch("target_value", longint'(oldest_result.target_value),
                             longint'(rsp_data.target_value));
            end
            if (rsp_data.predicted_value !== oldest_result.predicted_value) begin
               note_mismatch("predicted_value", longint'(oldest_result.predicted_value),
                             longint'(rsp_data.predicted_value));
            end
            if (rsp_data.squared_error !== oldest_result.squared_error) begin
               note_mismatch("squared_error", longint'({1'b0, oldest_result.squared_error}),
                             longint'({1'b0, rsp_data.squared_error}));
            end
            if (rsp_data.length_error !== oldest_result.length_error) begin
               note_mismatch("length_error", longint'(oldest_result.length_error),
                             longint'(rsp_data.length_error));
            end
         end
      end
   end

   // watchdog: any transaction on either channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles, %0d results pending",
                     $time, quiet_cycles, pending_results.size());
            $display("tb_mlp_forward_mse_loss NOT OK");
            $finish;
         end
      end
   end

endmodule
